[rtl/core/rotation_matrix_to_quaternion_top_defines.svh]
// Assertion macros shared by the rotation-matrix-to-quaternion RTL.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check that prop holds in the same cycle.
`define RMQ_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rmq assertion failed");
// Check that cons holds in the cycle after ante.
`define RMQ_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rmq assertion failed");
`else
`define RMQ_ASSERT(name, clk, rstn, prop)
`define RMQ_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

[rtl/core/rmq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

  // Fixed-point format of the matrix entries and the quaternion
  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int DIFF_W    = IN_W + 1;
  localparam int QW_W      = 15;
  localparam int Q_W       = 16;
  localparam int MAG_MAX   = 32767;
  localparam int ONE       = 1 << FRAC_BITS;

  // Radicand widths: unsigned after clamping, signed before
  localparam int UR_W  = (FRAC_BITS >= 17) ? FRAC_BITS + 1 : 18;
  localparam int RAD_W = UR_W + 1;

  // Square root operand: radicand scaled by 2^(FRAC_BITS-2)
  localparam int SH_W   = FRAC_BITS - 2;
  localparam int SQ_W   = UR_W + SH_W;
  localparam int ROOT_W = (SQ_W + 1) / 2;
  localparam int PAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  // Lane assignment
  localparam int NUM_LANES   = 4;
  localparam int LANE_SCALAR = 0;
  localparam int LANE_X      = 1;
  localparam int LANE_Y      = 2;
  localparam int LANE_Z      = 3;

  typedef struct packed {
    logic            neg;
    logic [UR_W-1:0] rad;
  } lane_in_t;

  typedef struct packed {
    logic              neg;
    logic [ROOT_W-1:0] mag;
  } lane_out_t;

endpackage

`default_nettype wire

[rtl/core/rmq_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rmq_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                vld_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0]     r00_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0]     r01_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0]     r02_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0]     r10_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0]     r11_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0]     r12_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0]     r20_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0]     r21_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0]     r22_i,
  output logic                                     vld_o,
  output rmq_pkg::lane_in_t [rmq_pkg::NUM_LANES-1:0] lane_o
);
  import rmq_pkg::*;

  logic signed [RAD_W-1:0]  one_s;
  logic signed [RAD_W-1:0]  e00;
  logic signed [RAD_W-1:0]  e11;
  logic signed [RAD_W-1:0]  e22;
  logic signed [RAD_W-1:0]  rad_s [NUM_LANES];
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dz;
  lane_in_t [NUM_LANES-1:0] lane_d;
  lane_in_t [NUM_LANES-1:0] lane_q;
  logic                     vld_q;

  // Form the four radicands from the diagonal
  assign one_s = RAD_W'(ONE);
  assign e00   = RAD_W'(r00_i);
  assign e11   = RAD_W'(r11_i);
  assign e22   = RAD_W'(r22_i);

  assign rad_s[LANE_SCALAR] = one_s + e00 + e11 + e22;
  assign rad_s[LANE_X]      = one_s + e00 - e11 - e22;
  assign rad_s[LANE_Y]      = one_s - e00 + e11 - e22;
  assign rad_s[LANE_Z]      = one_s - e00 - e11 + e22;

  // Off-diagonal differences set the signs of x, y and z
  assign dx = DIFF_W'(r21_i) - DIFF_W'(r12_i);
  assign dy = DIFF_W'(r02_i) - DIFF_W'(r20_i);
  assign dz = DIFF_W'(r10_i) - DIFF_W'(r01_i);

  // Clamp negative radicands to zero
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      lane_d[k].rad = rad_s[k][RAD_W-1] ? '0 : rad_s[k][UR_W-1:0];
    end
    lane_d[LANE_SCALAR].neg = 1'b0;
    lane_d[LANE_X].neg      = dx[DIFF_W-1];
    lane_d[LANE_Y].neg      = dy[DIFF_W-1];
    lane_d[LANE_Z].neg      = dz[DIFF_W-1];
  end

  // Advance the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  // Hold the lane operands
  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign vld_o  = vld_q;
  assign lane_o = lane_q;

endmodule

`default_nettype wire

[rtl/core/rmq_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root, one result bit per stage.
module rmq_lane (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               vld_i,
  input  wire rmq_pkg::lane_in_t  lane_i,
  output logic                    vld_o,
  output rmq_pkg::lane_out_t      lane_o
);
  import rmq_pkg::*;

  logic              vld_q  [ROOT_W];
  logic              neg_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [PAD_W-1:0]  sq_q   [ROOT_W];

  logic              p_neg  [ROOT_W];
  logic [REM_W-1:0]  p_rem  [ROOT_W];
  logic [ROOT_W-1:0] p_root [ROOT_W];
  logic [PAD_W-1:0]  p_sq   [ROOT_W];

  logic              n_neg  [ROOT_W];
  logic [REM_W-1:0]  n_rem  [ROOT_W];
  logic [ROOT_W-1:0] n_root [ROOT_W];
  logic [PAD_W-1:0]  n_sq   [ROOT_W];

  logic [REM_W-1:0]  shifted [ROOT_W];
  logic [REM_W-1:0]  trial   [ROOT_W];
  logic              ge      [ROOT_W];

  // Feed each stage from the one before it
  always_comb begin
    p_neg[0]  = lane_i.neg;
    p_rem[0]  = '0;
    p_root[0] = '0;
    p_sq[0]   = PAD_W'({lane_i.rad, {SH_W{1'b0}}});
    for (int i = 1; i < ROOT_W; i++) begin
      p_neg[i]  = neg_q[i-1];
      p_rem[i]  = rem_q[i-1];
      p_root[i] = root_q[i-1];
      p_sq[i]   = sq_q[i-1];
    end
  end

  // Bring down two operand bits and try the next root bit
  always_comb begin
    for (int i = 0; i < ROOT_W; i++) begin
      shifted[i] = {p_rem[i][REM_W-3:0], p_sq[i][PAD_W-1:PAD_W-2]};
      trial[i]   = {p_root[i], 2'b01};
      ge[i]      = shifted[i] >= trial[i];
      n_rem[i]   = ge[i] ? shifted[i] - trial[i] : shifted[i];
      n_root[i]  = {p_root[i][ROOT_W-2:0], ge[i]};
      n_sq[i]    = {p_sq[i][PAD_W-3:0], 2'b00};
      n_neg[i]   = p_neg[i];
    end
  end

  // Advance the stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROOT_W; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= vld_i;
      for (int i = 1; i < ROOT_W; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Advance the stage data
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ROOT_W; i++) begin
      neg_q[i]  <= n_neg[i];
      rem_q[i]  <= n_rem[i];
      root_q[i] <= n_root[i];
      sq_q[i]   <= n_sq[i];
    end
  end

  assign vld_o      = vld_q[ROOT_W-1];
  assign lane_o.neg = neg_q[ROOT_W-1];
  assign lane_o.mag = root_q[ROOT_W-1];

endmodule

`default_nettype wire

[rtl/core/rmq_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

module rmq_merge (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 vld_i,
  input  wire rmq_pkg::lane_out_t [rmq_pkg::NUM_LANES-1:0] lane_i,
  output logic                                      done_o,
  output logic        [rmq_pkg::QW_W-1:0]           qw_o,
  output logic signed [rmq_pkg::Q_W-1:0]            qx_o,
  output logic signed [rmq_pkg::Q_W-1:0]            qy_o,
  output logic signed [rmq_pkg::Q_W-1:0]            qz_o
);
  import rmq_pkg::*;

  logic [31:0]     mag_ext [NUM_LANES];
  logic [QW_W-1:0] mag_sat [NUM_LANES];
  logic [Q_W-1:0]  sgn     [NUM_LANES];
  logic            done_q;
  logic [QW_W-1:0] qw_q;
  logic [Q_W-1:0]  qx_q;
  logic [Q_W-1:0]  qy_q;
  logic [Q_W-1:0]  qz_q;

  // Saturate each magnitude, then apply the sign
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      mag_ext[k] = 32'(lane_i[k].mag);
      mag_sat[k] = (mag_ext[k] > 32'(MAG_MAX)) ? QW_W'(MAG_MAX) : mag_ext[k][QW_W-1:0];
      sgn[k]     = lane_i[k].neg ? (Q_W'(0) - {1'b0, mag_sat[k]}) : {1'b0, mag_sat[k]};
    end
  end

  // Raise the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_i;
    end
  end

  // Hold the result fields
  always_ff @(posedge clk_i) begin
    qw_q <= mag_sat[LANE_SCALAR];
    qx_q <= sgn[LANE_X];
    qy_q <= sgn[LANE_Y];
    qz_q <= sgn[LANE_Z];
  end

  assign done_o = done_q;
  assign qw_o   = qw_q;
  assign qx_o   = $signed(qx_q);
  assign qy_o   = $signed(qy_q);
  assign qz_o   = $signed(qz_q);

endmodule

`default_nettype wire

[rtl/core/rotation_matrix_to_quaternion_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Rotation matrix to quaternion, signed Q2.14 in and out (qw_o unsigned Q1.14).
// Input: drive the nine entries r00_i..r22_i and pulse start_i; an item is
// taken at each rising edge with start_i high and busy_o low. busy_o stays
// low, so a new item may enter in every cycle.
// Output: done_o is high for one cycle with qw_o, qx_o, qy_o and qz_o; the
// receiver must take the item in that cycle, it cannot hold results off.
// Path: the front registers the radicands and signs, the square-root
// pipelines follow (one root bit per stage, the stage count set by the
// 15-bit root width), and a last register applies saturation and sign.
// Throughput: one item per cycle.
// Four square-root lanes (w, x, y, z) run side by side on each item.
// Reset: rst_ni clears all valid flags; items in flight are dropped and no
// done_o pulse appears until a new item is taken.
`include "rotation_matrix_to_quaternion_top_defines.svh"

module rotation_matrix_to_quaternion_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic signed [rmq_pkg::IN_W-1:0] r00_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0] r01_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0] r02_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0] r10_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0] r11_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0] r12_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0] r20_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0] r21_i,
  input  wire logic signed [rmq_pkg::IN_W-1:0] r22_i,
  output logic                                 done_o,
  output logic        [rmq_pkg::QW_W-1:0]      qw_o,
  output logic signed [rmq_pkg::Q_W-1:0]       qx_o,
  output logic signed [rmq_pkg::Q_W-1:0]       qy_o,
  output logic signed [rmq_pkg::Q_W-1:0]       qz_o
);
  import rmq_pkg::*;

  logic                      accept;
  logic                      front_vld;
  lane_in_t  [NUM_LANES-1:0] front_lane;
  logic      [NUM_LANES-1:0] lane_vld;
  lane_out_t [NUM_LANES-1:0] lane_res;

  // Never stall the input
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  rmq_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (accept),
    .r00_i  (r00_i),
    .r01_i  (r01_i),
    .r02_i  (r02_i),
    .r10_i  (r10_i),
    .r11_i  (r11_i),
    .r12_i  (r12_i),
    .r20_i  (r20_i),
    .r21_i  (r21_i),
    .r22_i  (r22_i),
    .vld_o  (front_vld),
    .lane_o (front_lane)
  );

  // One square-root lane per quaternion component
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    rmq_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (front_vld),
      .lane_i (front_lane[k]),
      .vld_o  (lane_vld[k]),
      .lane_o (lane_res[k])
    );
  end

  rmq_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (lane_vld[LANE_SCALAR]),
    .lane_i (lane_res),
    .done_o (done_o),
    .qw_o   (qw_o),
    .qx_o   (qx_o),
    .qy_o   (qy_o),
    .qz_o   (qz_o)
  );

  // Lanes stay in lockstep
  `RMQ_ASSERT(a_lanes_lockstep, clk_i, rst_ni, (lane_vld == '0) || (lane_vld == '1))
  // Each finished lane item yields one strobe in the next cycle
  `RMQ_ASSERT_NEXT(a_done_follows, clk_i, rst_ni, lane_vld[LANE_SCALAR], done_o)
  `RMQ_ASSERT_NEXT(a_no_spurious_done, clk_i, rst_ni, !lane_vld[LANE_SCALAR], !done_o)
  // A negative nonzero x magnitude comes out negative
  `RMQ_ASSERT_NEXT(a_x_sign, clk_i, rst_ni,
                   lane_vld[LANE_X] && lane_res[LANE_X].neg && (lane_res[LANE_X].mag != '0),
                   qx_o[Q_W-1])

endmodule

`default_nettype wire

[dv/tb_rotation_matrix_to_quaternion_top.sv]
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion_top;
  import rmq_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int RESET_LEN   = 10;
  localparam int RANDOM_POSES = 1000;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [IN_W-1:0] entry_t;

  typedef struct packed {
    entry_t r00, r01, r02;
    entry_t r10, r11, r12;
    entry_t r20, r21, r22;
  } pose_t;

  typedef struct packed {
    logic        [QW_W-1:0] qw;
    logic signed [Q_W-1:0]  qx;
    logic signed [Q_W-1:0]  qy;
    logic signed [Q_W-1:0]  qz;
  } quat_t;

  // Exact integer square root, largest r with r*r <= v
  function automatic longint int_sqrt(longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Half the square root of a Q2.14 radicand, clamped below and saturated above
  function automatic longint half_sqrt(longint radicand);
    longint m;
    if (radicand < 0) radicand = 0;
    m = int_sqrt(radicand << (FRAC_BITS - 2));
    if (m > MAG_MAX) m = MAG_MAX;
    return m;
  endfunction

  // Negate the magnitude only when the off-diagonal difference is below zero
  function automatic logic signed [Q_W-1:0] signed_part(longint mag, longint diff);
    if (diff < 0) return Q_W'(-mag);
    return Q_W'(mag);
  endfunction

  function automatic quat_t predict_quat(pose_t p);
    quat_t  q;
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    a00 = p.r00; a01 = p.r01; a02 = p.r02;
    a10 = p.r10; a11 = p.r11; a12 = p.r12;
    a20 = p.r20; a21 = p.r21; a22 = p.r22;
    q.qw = QW_W'(half_sqrt(ONE + a00 + a11 + a22));
    q.qx = signed_part(half_sqrt(ONE + a00 - a11 - a22), a21 - a12);
    q.qy = signed_part(half_sqrt(ONE - a00 + a11 - a22), a02 - a20);
    q.qz = signed_part(half_sqrt(ONE - a00 - a11 + a22), a10 - a01);
    return q;
  endfunction

  class quat_scoreboard;
    quat_t expected_quats[$];
    int    failures;

    function new();
      failures = 0;
    endfunction

    function void note_pose(pose_t p);
      expected_quats.push_back(predict_quat(p));
    endfunction

    function int pending();
      return expected_quats.size();
    endfunction

    function void report_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        failures++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_quat(quat_t act);
      quat_t exp_q;
      if (expected_quats.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, actual qw %0d qx %0d qy %0d qz %0d",
                 $time, act.qw, act.qx, act.qy, act.qz);
        return;
      end
      exp_q = expected_quats.pop_front();
      report_field("qw", longint'(exp_q.qw), longint'(act.qw));
      report_field("qx", longint'(exp_q.qx), longint'(act.qx));
      report_field("qy", longint'(exp_q.qy), longint'(act.qy));
      report_field("qz", longint'(exp_q.qz), longint'(act.qz));
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   start_i;
  logic   busy_o;
  entry_t r00_i, r01_i, r02_i, r10_i, r11_i, r12_i, r20_i, r21_i, r22_i;
  logic                   done_o;
  logic        [QW_W-1:0] qw_o;
  logic signed [Q_W-1:0]  qx_o, qy_o, qz_o;

  quat_scoreboard sb;
  int unsigned    cycle_count;

  rotation_matrix_to_quaternion_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .r00_i  (r00_i),
    .r01_i  (r01_i),
    .r02_i  (r02_i),
    .r10_i  (r10_i),
    .r11_i  (r11_i),
    .r12_i  (r12_i),
    .r20_i  (r20_i),
    .r21_i  (r21_i),
    .r22_i  (r22_i),
    .done_o (done_o),
    .qw_o   (qw_o),
    .qx_o   (qx_o),
    .qy_o   (qy_o),
    .qz_o   (qz_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Check every result in the cycle its strobe is high
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_quat('{qw: qw_o, qx: qx_o, qy: qy_o, qz: qz_o});
  end

  function automatic pose_t make_pose(int a00, int a01, int a02, int a10, int a11,
                                      int a12, int a20, int a21, int a22);
    pose_t p;
    p.r00 = entry_t'(a00); p.r01 = entry_t'(a01); p.r02 = entry_t'(a02);
    p.r10 = entry_t'(a10); p.r11 = entry_t'(a11); p.r12 = entry_t'(a12);
    p.r20 = entry_t'(a20); p.r21 = entry_t'(a21); p.r22 = entry_t'(a22);
    return p;
  endfunction

  // Scale a real entry to Q2.14 with a little noise, clamp to the port range
  function automatic entry_t to_fixed(real v);
    int n;
    n = $rtoi(v * ONE + (v >= 0.0 ? 0.5 : -0.5));
    n = n + int'($urandom_range(0, 8)) - 4;
    if (n > 32767) n = 32767;
    if (n < -32768) n = -32768;
    return entry_t'(n);
  endfunction

  function automatic real rand_unit();
    return real'(int'($urandom_range(0, 20000)) - 10000) / 10000.0;
  endfunction

  // Build the matrix of a random unit quaternion
  function automatic pose_t rand_rotation();
    pose_t p;
    real   w, x, y, z, n;
    w = rand_unit(); x = rand_unit(); y = rand_unit(); z = rand_unit();
    n = $sqrt(w * w + x * x + y * y + z * z);
    if (n < 1.0e-3) begin
      w = 1.0; x = 0.0; y = 0.0; z = 0.0; n = 1.0;
    end
    w = w / n; x = x / n; y = y / n; z = z / n;
    p.r00 = to_fixed(1.0 - 2.0 * (y * y + z * z));
    p.r01 = to_fixed(2.0 * (x * y - w * z));
    p.r02 = to_fixed(2.0 * (x * z + w * y));
    p.r10 = to_fixed(2.0 * (x * y + w * z));
    p.r11 = to_fixed(1.0 - 2.0 * (x * x + z * z));
    p.r12 = to_fixed(2.0 * (y * z - w * x));
    p.r20 = to_fixed(2.0 * (x * z - w * y));
    p.r21 = to_fixed(2.0 * (y * z + w * x));
    p.r22 = to_fixed(1.0 - 2.0 * (x * x + y * y));
    return p;
  endfunction

  function automatic entry_t corner_entry();
    int corners[7] = '{-32768, -16384, -1, 0, 1, 16384, 32767};
    return entry_t'(corners[$urandom_range(0, 6)]);
  endfunction

  // Mostly valid rotations, then raw noise and corner values
  function automatic pose_t rand_pose();
    pose_t p;
    int    sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return rand_rotation();
    if (sel < 85) begin
      p = pose_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    end else begin
      p = make_pose(corner_entry(), corner_entry(), corner_entry(), corner_entry(),
                    corner_entry(), corner_entry(), corner_entry(), corner_entry(),
                    corner_entry());
    end
    return p;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item and hold it until it is taken
  task automatic send_pose(pose_t p);
    @(negedge clk_i);
    start_i = 1'b1;
    r00_i = p.r00; r01_i = p.r01; r02_i = p.r02;
    r10_i = p.r10; r11_i = p.r11; r12_i = p.r12;
    r20_i = p.r20; r21_i = p.r21; r22_i = p.r22;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_pose(p);
  endtask

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i = 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    pose_t directed[$];
    int    burst_left;

    sb          = new();
    cycle_count = 0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    {r00_i, r01_i, r02_i, r10_i, r11_i, r12_i, r20_i, r21_i, r22_i} = '0;
    repeat (RESET_LEN) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Identity and half turns about each axis
    directed.push_back(make_pose(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
    directed.push_back(make_pose(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    directed.push_back(make_pose(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
    directed.push_back(make_pose(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
    // Quarter turns about z in both directions, and one about x
    directed.push_back(make_pose(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
    directed.push_back(make_pose(0, 16384, 0, -16384, 0, 0, 0, 0, 16384));
    directed.push_back(make_pose(16384, 0, 0, 0, 0, 16384, 0, -16384, 0));
    // Field extremes
    directed.push_back(make_pose(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                 32767));
    directed.push_back(make_pose(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                                 -32768, -32768));
    directed.push_back(make_pose(32767, -32768, 32767, -32768, -32768, 32767, -32768,
                                 32767, -32768));
    directed.push_back(make_pose(-32768, 32767, -32768, 32767, 32767, -32768, 32767,
                                 -32768, 32767));
    // Largest radicands on each lane
    directed.push_back(make_pose(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
    directed.push_back(make_pose(32767, 0, 0, 0, -32768, 0, 0, 0, -32768));
    directed.push_back(make_pose(-32768, 0, 0, 0, 32767, 0, 0, 0, -32768));
    directed.push_back(make_pose(-32768, 0, 0, 0, -32768, 0, 0, 0, 32767));
    // Negative differences: zero x, y and z magnitudes, then a zero w magnitude
    directed.push_back(make_pose(16384, 100, -100, -100, 16384, 100, 100, -100, 16384));
    directed.push_back(make_pose(-16384, 5, -7, -5, -16384, 9, 7, -9, -16384));
    // Zero differences with nonzero w, x and y magnitudes
    directed.push_back(make_pose(8192, 300, -200, 300, 0, 50, -200, 50, -8192));
    // Radicand just below and just above zero
    directed.push_back(make_pose(-16385, 1, 1, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_pose(-16383, 0, 1, 1, 0, 0, 0, 1, 0));
    // Tiny radicand with the smallest nonzero magnitude
    directed.push_back(make_pose(0, -1, 0, 0, 0, 0, 0, 0, -16383));

    foreach (directed[i]) begin
      send_pose(directed[i]);
      idle($urandom_range(0, 2));
    end
    drain_results();

    burst_left = 0;
    for (int i = 0; i < RANDOM_POSES; i++) begin
      send_pose(rand_pose());
      // Every so often run back to back with no idling
      if (i % 200 == 100) burst_left = 40;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        idle(pick_gap());
      end
      // Hold off until every result is back
      if (i == RANDOM_POSES / 2 || $urandom_range(0, 99) == 0) drain_results();
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
